// ===== design/assert_macros.svh =====
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising clock edge outside reset
`define ASSERT_AT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`else

`define ASSERT_AT(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

// ===== design/yrgb_pkg.sv =====
package yrgb_pkg;

	// fixed point format of the color sums
	localparam int FRAC_BITS = 14;
	localparam int ACC_W     = 24;
	localparam int WHOLE_W   = ACC_W - FRAC_BITS;

	// Q2.14 coefficients
	localparam logic signed [ACC_W-1:0] COEF_R_CR = ACC_W'(22970);
	localparam logic signed [ACC_W-1:0] COEF_G_CB = ACC_W'(5636);
	localparam logic signed [ACC_W-1:0] COEF_G_CR = ACC_W'(11698);
	localparam logic signed [ACC_W-1:0] COEF_B_CB = ACC_W'(29032);

	// bias of two whole units added to red and blue
	localparam logic signed [ACC_W-1:0] RB_BIAS_Q = ACC_W'(2 << FRAC_BITS);

	// neutral chroma
	localparam logic [7:0]        CHROMA_OFFSET   = 8'd128;
	localparam logic signed [8:0] CHROMA_OFFSET_S = 9'sd128;

	// one pixel request from the pair register to the color math
	typedef struct packed {
		logic [7:0]        luma;
		logic signed [8:0] cb;
		logic signed [8:0] cr;
		logic              second;
	} pix_req_t;

	// pair register status toward the top level
	typedef struct packed {
		logic valid;
		logic odd;
	} pair_status_t;

	// one finished rgb pixel
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       second;
	} pix_rgb_t;

endpackage

// ===== design/yrgb_pair_if.sv =====
interface yrgb_pair_if;
	logic       valid;
	logic       ready;
	logic [7:0] luma_even;
	logic [7:0] chroma_blue;
	logic [7:0] luma_odd;
	logic [7:0] chroma_red;
	logic       row_start;

	modport source (
		output valid, luma_even, chroma_blue, luma_odd, chroma_red, row_start,
		input  ready
	);

	modport sink (
		input  valid, luma_even, chroma_blue, luma_odd, chroma_red, row_start,
		output ready
	);
endinterface

// ===== design/yrgb_pixel_if.sv =====
interface yrgb_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       second_of_pair;

	modport source (
		output valid, red, green, blue, second_of_pair,
		input  ready
	);

	modport sink (
		input  valid, red, green, blue, second_of_pair,
		output ready
	);
endinterface

// ===== design/yrgb_pair_reg.sv =====
module yrgb_pair_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	yrgb_pair_if.sink             pairs,
	input  logic                  advance,
	output yrgb_pkg::pair_status_t status,
	output yrgb_pkg::pix_req_t     req
);

	logic              full_q;
	logic              odd_q;
	logic [7:0]        held_cr_q;
	logic [7:0]        luma_even_s1;
	logic [7:0]        luma_odd_s1;
	logic signed [8:0] cb_s1;
	logic signed [8:0] cr_even_s1;
	logic signed [8:0] cr_odd_s1;
	logic              take;
	logic [7:0]        cr_even_raw;

	// free slot, or the odd pixel leaves in this cycle
	assign pairs.ready = !full_q || (odd_q && advance);
	assign take        = pairs.valid && pairs.ready;

	// even pixel takes the held cr unless a row begins here
	assign cr_even_raw = pairs.row_start ? pairs.chroma_red : held_cr_q;

	// control state and held chroma
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q    <= 1'b0;
			odd_q     <= 1'b0;
			held_cr_q <= yrgb_pkg::CHROMA_OFFSET;
		end else begin
			if (take) begin
				full_q    <= 1'b1;
				odd_q     <= 1'b0;
				held_cr_q <= pairs.chroma_red;
			end else if (advance) begin
				if (odd_q) begin
					full_q <= 1'b0;
				end
				odd_q <= !odd_q;
			end
		end
	end

	// pair payload, chroma made signed on the way in
	always_ff @(posedge clk) begin
		if (take) begin
			luma_even_s1 <= pairs.luma_even;
			luma_odd_s1  <= pairs.luma_odd;
			cb_s1        <= signed'({1'b0, pairs.chroma_blue}) - yrgb_pkg::CHROMA_OFFSET_S;
			cr_even_s1   <= signed'({1'b0, cr_even_raw}) - yrgb_pkg::CHROMA_OFFSET_S;
			cr_odd_s1    <= signed'({1'b0, pairs.chroma_red}) - yrgb_pkg::CHROMA_OFFSET_S;
		end
	end

	// pick the pending pixel of the pair
	always_comb begin
		req.luma   = odd_q ? luma_odd_s1 : luma_even_s1;
		req.cb     = cb_s1;
		req.cr     = odd_q ? cr_odd_s1 : cr_even_s1;
		req.second = odd_q;
	end

	assign status.valid = full_q;
	assign status.odd   = odd_q;

endmodule

// ===== design/yrgb_color_math.sv =====
module yrgb_color_math (
	input  yrgb_pkg::pix_req_t req,
	output yrgb_pkg::pix_rgb_t rgb
);

	logic signed [yrgb_pkg::ACC_W-1:0] ys;
	logic signed [yrgb_pkg::ACC_W-1:0] cb_x;
	logic signed [yrgb_pkg::ACC_W-1:0] cr_x;
	logic signed [yrgb_pkg::ACC_W-1:0] r_acc;
	logic signed [yrgb_pkg::ACC_W-1:0] g_acc;
	logic signed [yrgb_pkg::ACC_W-1:0] b_acc;

	// floor to whole units and clamp to 0..255
	function automatic logic [7:0] sat_floor(input logic signed [yrgb_pkg::ACC_W-1:0] acc);
		logic [yrgb_pkg::WHOLE_W-1:0] whole;
		logic [7:0]                   res;
		whole = acc[yrgb_pkg::ACC_W-1:yrgb_pkg::FRAC_BITS];
		if (whole[yrgb_pkg::WHOLE_W-1]) begin
			res = 8'd0;
		end else if (whole[yrgb_pkg::WHOLE_W-2:8] != '0) begin
			res = 8'd255;
		end else begin
			res = whole[7:0];
		end
		return res;
	endfunction

	// luma scaled up, chroma sign extended
	assign ys   = signed'({2'b00, req.luma, {yrgb_pkg::FRAC_BITS{1'b0}}});
	assign cb_x = yrgb_pkg::ACC_W'(req.cb);
	assign cr_x = yrgb_pkg::ACC_W'(req.cr);

	// color sums
	assign r_acc = ys + cr_x * yrgb_pkg::COEF_R_CR + yrgb_pkg::RB_BIAS_Q;
	assign g_acc = ys - cb_x * yrgb_pkg::COEF_G_CB - cr_x * yrgb_pkg::COEF_G_CR;
	assign b_acc = ys + cb_x * yrgb_pkg::COEF_B_CB + yrgb_pkg::RB_BIAS_Q;

	assign rgb.red    = sat_floor(r_acc);
	assign rgb.green  = sat_floor(g_acc);
	assign rgb.blue   = sat_floor(b_acc);
	assign rgb.second = req.second;

endmodule

// ===== design/yuv422_to_rgb_pixel_stream_unit.sv =====
// YUV 4:2:2 to RGB converter, BT.601 style coefficients.
// pairs: one request carries a pixel pair (even luma, Cb, odd luma, Cr,
//   row start flag). pixels: two requests come out for each pair, the even
//   pixel first (second_of_pair low), then the odd one (second_of_pair high).
// The even pixel uses the Cr of the previous pair unless row_start is set.
// Path: an accepted pair is held in the pair register; its even pixel, then
//   its odd pixel, is registered in the output register when that is free.
// Throughput: one pixel per cycle while pairs arrive and ready stays high,
//   through a single output register. A new pair is accepted in the same
//   cycle the odd pixel of the previous pair moves to the output register.
// Reset clears both registers to empty and sets the held Cr to 128.
// When the receiver holds ready low the output pixel stays put, the pair
//   register holds its pending pixel, and pairs.ready drops once that
//   register is full.
`include "assert_macros.svh"

module yuv422_to_rgb_pixel_stream_unit (
	input  logic         clk,
	input  logic         arst_n,
	yrgb_pair_if.sink    pairs,
	yrgb_pixel_if.source pixels
);

	yrgb_pkg::pair_status_t status;
	yrgb_pkg::pix_req_t     req;
	yrgb_pkg::pix_rgb_t     rgb;
	yrgb_pkg::pix_rgb_t     out_s2;
	logic                   out_valid_q;
	logic                   advance;

	// pixel moves on when the output register is free or emptying
	assign advance = status.valid && (!out_valid_q || pixels.ready);

	yrgb_pair_reg u_pair_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.pairs   (pairs),
		.advance (advance),
		.status  (status),
		.req     (req)
	);

	yrgb_color_math u_color_math (
		.req (req),
		.rgb (rgb)
	);

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (pixels.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output pixel
	always_ff @(posedge clk) begin
		if (advance) begin
			out_s2 <= rgb;
		end
	end

	assign pixels.valid          = out_valid_q;
	assign pixels.red            = out_s2.red;
	assign pixels.green          = out_s2.green;
	assign pixels.blue           = out_s2.blue;
	assign pixels.second_of_pair = out_s2.second;

	// checks
	`ASSERT_AT(a_pair_starts_even, clk, arst_n, (pairs.valid && pairs.ready) |=> (status.valid && !status.odd), "accepted pair must start with its even pixel")
	`ASSERT_NEVER(a_no_take_while_even, clk, arst_n, status.valid && !status.odd && pairs.ready, "pair accepted while an even pixel is pending")
	`ASSERT_AT(a_order_kept, clk, arst_n, advance |=> (out_valid_q && (out_s2.second == $past(status.odd))), "output pixel order does not follow the pair register")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	// fixed point terms of the color math, Q2.14
	localparam int FRAC   = 14;
	localparam int K_R_CR = 22970;
	localparam int K_G_CB = 5636;
	localparam int K_G_CR = 11698;
	localparam int K_B_CB = 29032;
	localparam int NEUTRAL = 128;
	localparam int RB_LIFT = 2;

	localparam int RANDOM_PAIRS = 1250;
	localparam int CYCLE_LIMIT  = 800000;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic [7:0] y0;
		logic [7:0] cb;
		logic [7:0] y1;
		logic [7:0] cr;
		logic       rs;
	} pair_t;

	typedef struct packed {
		pair_t              pair;
		logic               typed;
		yrgb_pkg::pix_rgb_t even;
		yrgb_pkg::pix_rgb_t odd;
	} dir_row_t;

	localparam yrgb_pkg::pix_rgb_t NONE = '0;
	localparam int N_DIR = 21;

	// directed pairs; typed rows carry their pixels, the rest go through the predictor
	localparam dir_row_t DIRECTED [N_DIR] = '{
		// first pair after reset without row start, even pixel on the reset Cr
		'{'{8'd100, 8'd128, 8'd100, 8'd255, 1'b0}, 1'b0, NONE, NONE},
		'{'{8'd0, 8'd128, 8'd255, 8'd128, 1'b1}, 1'b1,
			'{8'd2, 8'd0, 8'd2, 1'b0}, '{8'd255, 8'd255, 8'd255, 1'b1}},
		'{'{8'd128, 8'd128, 8'd254, 8'd128, 1'b0}, 1'b1,
			'{8'd130, 8'd128, 8'd130, 1'b0}, '{8'd255, 8'd254, 8'd255, 1'b1}},
		'{'{8'd253, 8'd128, 8'd1, 8'd128, 1'b0}, 1'b1,
			'{8'd255, 8'd253, 8'd255, 1'b0}, '{8'd3, 8'd1, 8'd3, 1'b1}},
		'{'{8'd0, 8'd0, 8'd0, 8'd0, 1'b1}, 1'b0, NONE, NONE},
		'{'{8'd255, 8'd255, 8'd255, 8'd255, 1'b1}, 1'b0, NONE, NONE},
		'{'{8'd255, 8'd0, 8'd255, 8'd0, 1'b0}, 1'b0, NONE, NONE},
		'{'{8'd0, 8'd255, 8'd0, 8'd255, 1'b0}, 1'b0, NONE, NONE},
		'{'{8'd128, 8'd0, 8'd128, 8'd255, 1'b0}, 1'b0, NONE, NONE},
		'{'{8'd128, 8'd255, 8'd128, 8'd0, 1'b1}, 1'b0, NONE, NONE},
		'{'{8'd16, 8'd128, 8'd235, 8'd128, 1'b1}, 1'b1,
			'{8'd18, 8'd16, 8'd18, 1'b0}, '{8'd237, 8'd235, 8'd237, 1'b1}},
		'{'{8'd16, 8'd240, 8'd235, 8'd16, 1'b0}, 1'b0, NONE, NONE},
		'{'{8'd81, 8'd90, 8'd81, 8'd240, 1'b0}, 1'b0, NONE, NONE},
		'{'{8'd41, 8'd240, 8'd41, 8'd110, 1'b1}, 1'b0, NONE, NONE},
		'{'{8'd145, 8'd54, 8'd145, 8'd34, 1'b0}, 1'b0, NONE, NONE},
		'{'{8'd0, 8'd128, 8'd0, 8'd128, 1'b1}, 1'b1,
			'{8'd2, 8'd0, 8'd2, 1'b0}, '{8'd2, 8'd0, 8'd2, 1'b1}},
		'{'{8'd255, 8'd128, 8'd255, 8'd128, 1'b0}, 1'b1,
			'{8'd255, 8'd255, 8'd255, 1'b0}, '{8'd255, 8'd255, 8'd255, 1'b1}},
		'{'{8'd170, 8'd85, 8'd170, 8'd170, 1'b0}, 1'b0, NONE, NONE},
		'{'{8'd85, 8'd170, 8'd85, 8'd85, 1'b1}, 1'b0, NONE, NONE},
		'{'{8'd1, 8'd1, 8'd254, 8'd254, 1'b0}, 1'b0, NONE, NONE},
		'{'{8'd254, 8'd254, 8'd1, 8'd1, 1'b1}, 1'b0, NONE, NONE}
	};

	logic clk;
	logic arst_n;

	yrgb_pair_if  pairs_bus ();
	yrgb_pixel_if pixels_bus ();

	yuv422_to_rgb_pixel_stream_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pairs  (pairs_bus),
		.pixels (pixels_bus)
	);

	yrgb_pkg::pix_rgb_t pixels_due[$];
	logic [7:0]         last_cr;
	int                 err_count;
	int                 cycles;
	int                 pairs_sent;
	int                 pixels_seen;
	int                 row_starts;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels outstanding", cycles,
				pixels_due.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		err_count++;
	endtask

	// floor a Q.14 sum and clamp it to a byte
	function automatic logic [7:0] floor_clamp(input int acc);
		int whole;
		whole = acc >>> FRAC;
		if (whole < 0)
			return 8'd0;
		if (whole > 255)
			return 8'd255;
		return whole[7:0];
	endfunction

	function automatic yrgb_pkg::pix_rgb_t rgb_pixel(input logic [7:0] y, input int cb,
			input int cr, input logic second);
		yrgb_pkg::pix_rgb_t px;
		int ys;
		ys = int'(y) * (1 << FRAC);
		px.red    = floor_clamp(ys + K_R_CR * cr + (RB_LIFT << FRAC));
		px.green  = floor_clamp(ys - K_G_CB * cb - K_G_CR * cr);
		px.blue   = floor_clamp(ys + K_B_CB * cb + (RB_LIFT << FRAC));
		px.second = second;
		return px;
	endfunction

	// expected pixels of one accepted pair; updates the held Cr
	task automatic convert_pair(input pair_t p, input logic typed,
			input yrgb_pkg::pix_rgb_t even, input yrgb_pkg::pix_rgb_t odd);
		int cb;
		int cr_odd;
		int cr_even;
		cb      = int'(p.cb) - NEUTRAL;
		cr_odd  = int'(p.cr) - NEUTRAL;
		cr_even = p.rs ? cr_odd : int'(last_cr) - NEUTRAL;
		if (typed) begin
			pixels_due.push_back(even);
			pixels_due.push_back(odd);
		end else begin
			pixels_due.push_back(rgb_pixel(p.y0, cb, cr_even, 1'b0));
			pixels_due.push_back(rgb_pixel(p.y1, cb, cr_odd, 1'b1));
		end
		last_cr = p.cr;
		if (p.rs)
			row_starts++;
	endtask

	// mostly short gaps, a few long ones
	function automatic int pick_gap(input bit burst);
		int roll;
		if (burst)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 2);
		if (roll < 95)
			return $urandom_range(3, 8);
		return $urandom_range(10, 40);
	endfunction

	// samples leaning on the extremes and on neutral chroma
	function automatic logic [7:0] pick_sample(input bit chroma);
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return chroma ? 8'($urandom_range(120, 136)) : 8'($urandom_range(0, 20));
			3: return chroma ? 8'd128 : 8'($urandom_range(235, 255));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// drive one pair after a gap and wait for it to be taken
	task automatic send_pair(input pair_t p, input int gap, input logic typed,
			input yrgb_pkg::pix_rgb_t even, input yrgb_pkg::pix_rgb_t odd);
		repeat (gap) begin
			@(negedge clk);
			pairs_bus.valid <= 1'b0;
		end
		@(negedge clk);
		pairs_bus.valid       <= 1'b1;
		pairs_bus.luma_even   <= p.y0;
		pairs_bus.chroma_blue <= p.cb;
		pairs_bus.luma_odd    <= p.y1;
		pairs_bus.chroma_red  <= p.cr;
		pairs_bus.row_start   <= p.rs;
		do
			@(posedge clk);
		while (!pairs_bus.ready);
		convert_pair(p, typed, even, odd);
		pairs_sent++;
	endtask

	// pixel receiver: runs of ready, stalls mostly short
	initial begin
		int run;
		int stall;
		pixels_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			run = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
			repeat (run) @(negedge clk) pixels_bus.ready <= 1'b1;
			stall = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
			repeat (stall) @(negedge clk) pixels_bus.ready <= 1'b0;
		end
	end

	// pixel checker
	always @(posedge clk) begin
		yrgb_pkg::pix_rgb_t want;
		if (arst_n && pixels_bus.valid && pixels_bus.ready) begin
			pixels_seen++;
			if (pixels_due.size() == 0) begin
				report($sformatf("unexpected pixel r=%0d g=%0d b=%0d second=%0b",
					pixels_bus.red, pixels_bus.green, pixels_bus.blue,
					pixels_bus.second_of_pair));
			end else begin
				want = pixels_due.pop_front();
				if (pixels_bus.red !== want.red)
					report($sformatf("red %0d, want %0d", pixels_bus.red, want.red));
				if (pixels_bus.green !== want.green)
					report($sformatf("green %0d, want %0d", pixels_bus.green, want.green));
				if (pixels_bus.blue !== want.blue)
					report($sformatf("blue %0d, want %0d", pixels_bus.blue, want.blue));
				if (pixels_bus.second_of_pair !== want.second)
					report($sformatf("second_of_pair %0b, want %0b",
						pixels_bus.second_of_pair, want.second));
			end
		end
	end

	// stimulus and end of run
	initial begin
		pair_t p;
		int    left;
		int    row_len;
		bit    burst;
		err_count   = 0;
		pairs_sent  = 0;
		pixels_seen = 0;
		row_starts  = 0;
		last_cr     = 8'(NEUTRAL);
		arst_n      = 1'b0;
		pairs_bus.valid       = 1'b0;
		pairs_bus.luma_even   = 8'd0;
		pairs_bus.chroma_blue = 8'd0;
		pairs_bus.luma_odd    = 8'd0;
		pairs_bus.chroma_red  = 8'd0;
		pairs_bus.row_start   = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int i = 0; i < N_DIR; i++)
			send_pair(DIRECTED[i].pair, pick_gap(1'b0), DIRECTED[i].typed,
				DIRECTED[i].even, DIRECTED[i].odd);

		// random rows, row start on the first pair, a few broken flags
		left = RANDOM_PAIRS;
		while (left > 0) begin
			row_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24);
			burst   = ($urandom_range(0, 4) == 0);
			for (int k = 0; k < row_len && left > 0; k++) begin
				p.y0 = pick_sample(1'b0);
				p.cb = pick_sample(1'b1);
				p.y1 = pick_sample(1'b0);
				p.cr = pick_sample(1'b1);
				p.rs = (k == 0);
				if ($urandom_range(0, 11) == 0)
					p.rs = 1'($urandom_range(0, 1));
				send_pair(p, pick_gap(burst), 1'b0, NONE, NONE);
				left--;
			end
		end
		@(negedge clk);
		pairs_bus.valid <= 1'b0;

		// drain
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pixels_due.size() != 0)
			report($sformatf("%0d pixels never arrived", pixels_due.size()));

		$display("sent %0d pairs (%0d from the table) with %0d row starts", pairs_sent,
			N_DIR, row_starts);
		$display("checked %0d pixels against the predictor in %0d cycles", pixels_seen,
			cycles);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/yrgb_pkg.sv
design/yrgb_pair_if.sv
design/yrgb_pixel_if.sv
design/yrgb_pair_reg.sv
design/yrgb_color_math.sv
design/yuv422_to_rgb_pixel_stream_unit.sv
bench/testbench.sv
